// ----- hw/rtl/lmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lmpd_pkg: shared types and constants of the local-maximum peak detector
// Holds geometry limits, divider widths, controller codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lmpd_pkg;

   localparam int unsigned MaxWidth  = 4096;
   localparam int unsigned MaxHeight = 4096;
   localparam int unsigned ColBits   = $clog2(MaxWidth);
   localparam int unsigned RowBits   = 12;
   localparam int unsigned PixBits   = 32;
   localparam int unsigned GeoBits   = 13;
   localparam int unsigned SigmaBits = 31;
   localparam int unsigned DivBits   = 40;               // signed divider operands
   localparam int unsigned QuoBits   = DivBits + 16;     // dividend after scaling
   localparam int unsigned CntBits   = $clog2(QuoBits);
   localparam int unsigned OffBits   = 30;               // holds +-2^28
   localparam int unsigned NumDivs   = 5;
   localparam int unsigned SelBits   = 3;

   // register indexes of the write port
   localparam logic [1:0] CsrWidth  = 2'd0;
   localparam logic [1:0] CsrHeight = 2'd1;
   localparam logic [1:0] CsrSigma  = 2'd2;

   // division jobs, in issue order
   localparam logic [SelBits-1:0] DivSig = 3'd0;
   localparam logic [SelBits-1:0] DivE1  = 3'd1;
   localparam logic [SelBits-1:0] DivE2  = 3'd2;
   localparam logic [SelBits-1:0] DivOx  = 3'd3;
   localparam logic [SelBits-1:0] DivOy  = 3'd4;

   typedef enum logic [1:0] {
      SAT_SIG   = 2'b00,
      SAT_ELLIP = 2'b01,
      SAT_POS   = 2'b10
   } sat_kind_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SHIFT = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_SPARE = 6'b100000
   } ctl_state_type;

   typedef struct packed {
      logic                accept;
      logic                shift;
      logic                div_start;
      logic [SelBits-1:0]  div_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic peak;
      logic div_done;
   } dp_sts_type;

   // magnitude limit of a saturated quotient
   function automatic logic [QuoBits-1:0] sat_cap(sat_kind_type kind, logic neg);
      logic [QuoBits-1:0] cap;
      begin
         case (kind)
            SAT_SIG:   cap = neg ? QuoBits'(64'h8000_0000) : QuoBits'(64'h7FFF_FFFF);
            SAT_ELLIP: cap = neg ? QuoBits'(64'h8000) : QuoBits'(64'h7FFF);
            SAT_POS:   cap = QuoBits'(64'h1000_0000);
            default:   cap = '0;
         endcase
         return cap;
      end
   endfunction

endpackage

// ----- hw/rtl/lmpd_div.sv -----
// ----------------------------------------------------------------------------
// lmpd_div: saturating restoring divider
// One quotient bit per cycle of trunc(|n|*2^s/|d|), sign restored and
// saturated to the range of the job.
// ----------------------------------------------------------------------------
module lmpd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lmpd_pkg::DivBits-1:0] num,
   input  logic signed [lmpd_pkg::DivBits-1:0] den,
   input  lmpd_pkg::sat_kind_type              kind,
   output logic                                done,
   output logic signed [lmpd_pkg::DivBits-1:0] result
);

   localparam int unsigned DW = lmpd_pkg::DivBits;
   localparam int unsigned QW = lmpd_pkg::QuoBits;
   localparam int unsigned CW = lmpd_pkg::CntBits;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic [DW-1:0]           ud_ff, ud_in;
   logic                    neg_ff, neg_in;
   logic                    zero_ff, zero_in;
   lmpd_pkg::sat_kind_type  kind_ff, kind_in;

   logic [DW-1:0]           un;
   logic [DW:0]             trial;
   logic [QW-1:0]           cap;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      kind_in = kind_ff;
      un      = num[DW-1] ? DW'(-num) : DW'(num);
      trial   = {rem_ff, quo_ff[QW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW - 1);
         rem_in  = '0;
         ud_in   = den[DW-1] ? DW'(-den) : DW'(den);
         neg_in  = num[DW-1] ^ den[DW-1];
         kind_in = kind;
         // zero numerator, or a zero denominator outside significance, gives 0
         zero_in = (num == '0) || ((den == '0) && (kind != lmpd_pkg::SAT_SIG));
         quo_in  = (kind == lmpd_pkg::SAT_ELLIP) ? {2'b00, un, 14'd0} : {un, 16'd0};
      end else if (busy_ff) begin
         if (trial >= {1'b0, ud_ff}) begin
            rem_in = DW'(trial - {1'b0, ud_ff});
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      cap = lmpd_pkg::sat_cap(kind_ff, neg_ff);
      if (zero_ff) begin
         result = '0;
      end else if (quo_ff > cap) begin
         result = neg_ff ? -$signed(DW'(cap)) : $signed(DW'(cap));
      end else begin
         result = neg_ff ? -$signed(DW'(quo_ff)) : $signed(DW'(quo_ff));
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      ud_ff   <= ud_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      kind_ff <= kind_in;
   end

endmodule

// ----- hw/rtl/lmpd_ctl.sv -----
// ----------------------------------------------------------------------------
// lmpd_ctl: controller of the peak detector
// Sequences pixel intake, window update, peak test, the five divisions and
// the result handshake.
// ----------------------------------------------------------------------------
module lmpd_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   input  lmpd_pkg::dp_sts_type  sts,
   output lmpd_pkg::ctl_cmd_type cmd
);

   lmpd_pkg::ctl_state_type          state_ff, state_in;
   logic [lmpd_pkg::SelBits-1:0]     idx_ff, idx_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd.accept    = 1'b0;
      cmd.shift     = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_sel   = lmpd_pkg::DivSig;
      in_ready      = 1'b0;
      out_valid     = 1'b0;
      case (state_ff)
         lmpd_pkg::ST_IDLE: begin
            in_ready   = 1'b1;
            cmd.accept = in_valid;
            if (in_valid) state_in = lmpd_pkg::ST_SHIFT;
         end
         lmpd_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = lmpd_pkg::ST_CHECK;
         end
         lmpd_pkg::ST_CHECK: begin
            if (sts.peak) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = lmpd_pkg::DivSig;
               idx_in        = lmpd_pkg::DivSig;
               state_in      = lmpd_pkg::ST_DIV;
            end else begin
               state_in = lmpd_pkg::ST_IDLE;
            end
         end
         lmpd_pkg::ST_DIV: begin
            if (sts.div_done) begin
               if (idx_ff == lmpd_pkg::DivOy) begin
                  state_in = lmpd_pkg::ST_OUT;
               end else begin
                  idx_in        = idx_ff + 1'b1;
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = idx_ff + 1'b1;
               end
            end
         end
         lmpd_pkg::ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = lmpd_pkg::ST_IDLE;
         end
         default: begin
            state_in = lmpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmpd_pkg::ST_IDLE;
         idx_ff   <= lmpd_pkg::DivSig;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- hw/rtl/lmpd_dp.sv -----
// ----------------------------------------------------------------------------
// lmpd_dp: datapath of the peak detector
// Line stores, 3x3 window, raster counters, configuration registers, peak
// test, divider operands and result registers.
// ----------------------------------------------------------------------------
module lmpd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lmpd_pkg::ctl_cmd_type                  cmd,
   output lmpd_pkg::dp_sts_type                   sts,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_addr,
   input  logic [lmpd_pkg::SigmaBits-1:0]         csr_wdata,
   input  logic signed [lmpd_pkg::PixBits-1:0]    pixel_value,
   output logic [lmpd_pkg::RowBits-1:0]           peak_row,
   output logic [lmpd_pkg::RowBits-1:0]           peak_col,
   output logic signed [31:0]                     peak_value,
   output logic signed [31:0]                     significance,
   output logic signed [15:0]                     ellipticity_one,
   output logic signed [15:0]                     ellipticity_two,
   output logic [28:0]                            pos_x,
   output logic [28:0]                            pos_y
);

   localparam int unsigned DW = lmpd_pkg::DivBits;
   localparam int unsigned PW = lmpd_pkg::PixBits;
   localparam int unsigned GW = lmpd_pkg::GeoBits;
   localparam int unsigned CB = lmpd_pkg::ColBits;
   localparam int unsigned RB = lmpd_pkg::RowBits;
   localparam int unsigned OW = lmpd_pkg::OffBits;

   logic [PW-1:0] upper_mem [lmpd_pkg::MaxWidth];
   logic [PW-1:0] lower_mem [lmpd_pkg::MaxWidth];
   logic [PW-1:0] up_rd_ff, mid_rd_ff, pix_ff;

   logic signed [PW-1:0] win_ff [9];
   logic signed [PW-1:0] win_in [9];

   logic [GW-1:0]        width_ff, height_ff;
   logic [lmpd_pkg::SigmaBits-1:0] sigma_ff;
   logic [RB-1:0]        row_ff, row_in;
   logic [CB-1:0]        col_ff, col_in;
   logic [RB-1:0]        cand_row_ff;
   logic [CB-1:0]        cand_col_ff;
   logic                 range_ff;

   logic [GW-1:0]        w_eff, h_eff, col_nx, row_nx;
   logic                 all_less;

   logic signed [DW-1:0] f, u, d, l, rt, q11, q22, sum, cor, fx, fy;
   logic signed [DW-1:0] num, den, div_res;
   lmpd_pkg::sat_kind_type kind;
   logic                 div_done;
   logic [lmpd_pkg::SelBits-1:0] sel_ff;

   logic signed [31:0]   sig_ff;
   logic signed [15:0]   e1_ff, e2_ff;
   logic signed [OW-1:0] offx_ff, offy_ff;
   logic signed [31:0]   px, py;

   // geometry clamp and raster counters
   always_comb begin
      w_eff = width_ff;
      if (width_ff < GW'(3)) w_eff = GW'(3);
      if (width_ff > GW'(lmpd_pkg::MaxWidth)) w_eff = GW'(lmpd_pkg::MaxWidth);
      h_eff = height_ff;
      if (height_ff < GW'(3)) h_eff = GW'(3);
      if (height_ff > GW'(lmpd_pkg::MaxHeight)) h_eff = GW'(lmpd_pkg::MaxHeight);
      col_nx = GW'(col_ff) + 1'b1;
      row_nx = GW'(row_ff) + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.shift) begin
         if (col_nx >= w_eff) begin
            col_in = '0;
            row_in = (row_nx >= h_eff) ? '0 : row_nx[RB-1:0];
         end else begin
            col_in = col_nx[CB-1:0];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) win_in[k] = win_ff[k];
      if (cmd.shift) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = up_rd_ff;
         win_in[5] = mid_rd_ff;
         win_in[8] = pix_ff;
      end
   end

   always_comb begin
      all_less = 1'b1;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && win_ff[k] >= win_ff[4]) all_less = 1'b0;
      end
   end
   assign sts.peak = range_ff && all_less;

   // divider operands
   always_comb begin
      f   = DW'(win_ff[4]);
      u   = DW'(win_ff[1]);
      d   = DW'(win_ff[7]);
      l   = DW'(win_ff[3]);
      rt  = DW'(win_ff[5]);
      q11 = (f <<< 1) - u - d;
      q22 = (f <<< 1) - l - rt;
      sum = q11 + q22;
      cor = DW'(win_ff[8]) - DW'(win_ff[6]) - DW'(win_ff[2]) + DW'(win_ff[0]);
      fx  = rt - (f <<< 1) + l;
      fy  = d - (f <<< 1) + u;
      case (cmd.div_sel)
         lmpd_pkg::DivSig: begin
            num = f; den = $signed(DW'(sigma_ff)); kind = lmpd_pkg::SAT_SIG;
         end
         lmpd_pkg::DivE1: begin
            num = q22 - q11; den = sum; kind = lmpd_pkg::SAT_ELLIP;
         end
         lmpd_pkg::DivE2: begin
            num = cor; den = sum <<< 1; kind = lmpd_pkg::SAT_ELLIP;
         end
         lmpd_pkg::DivOx: begin
            num = rt - l; den = fx <<< 1; kind = lmpd_pkg::SAT_POS;
         end
         lmpd_pkg::DivOy: begin
            num = d - u; den = fy <<< 1; kind = lmpd_pkg::SAT_POS;
         end
         default: begin
            num = '0; den = '0; kind = lmpd_pkg::SAT_SIG;
         end
      endcase
   end

   lmpd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num    (num),
      .den    (den),
      .kind   (kind),
      .done   (div_done),
      .result (div_res)
   );
   assign sts.div_done = div_done;

   // line stores
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= lower_mem[col_ff];
         pix_ff    <= pixel_value;
      end
      if (cmd.shift) begin
         upper_mem[col_ff] <= mid_rd_ff;
         lower_mem[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         range_ff  <= 1'b0;
         width_ff  <= GW'(1024);
         height_ff <= GW'(1024);
         sigma_ff  <= lmpd_pkg::SigmaBits'(65536);
      end else begin
         for (int k = 0; k < 9; k++) win_ff[k] <= win_in[k];
         row_ff <= row_in;
         col_ff <= col_in;
         if (cmd.shift) begin
            range_ff <= (row_ff >= RB'(2)) && (GW'(row_ff) < h_eff) &&
                        (col_ff >= CB'(2)) && (GW'(col_ff) < w_eff);
         end
         if (csr_we) begin
            case (csr_addr)
               lmpd_pkg::CsrWidth:  width_ff  <= csr_wdata[GW-1:0];
               lmpd_pkg::CsrHeight: height_ff <= csr_wdata[GW-1:0];
               lmpd_pkg::CsrSigma:  sigma_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // candidate position and division results
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         cand_row_ff <= row_ff;
         cand_col_ff <= col_ff;
      end
      if (cmd.div_start) sel_ff <= cmd.div_sel;
      if (div_done) begin
         case (sel_ff)
            lmpd_pkg::DivSig: sig_ff  <= div_res[31:0];
            lmpd_pkg::DivE1:  e1_ff   <= div_res[15:0];
            lmpd_pkg::DivE2:  e2_ff   <= div_res[15:0];
            lmpd_pkg::DivOx:  offx_ff <= div_res[OW-1:0];
            lmpd_pkg::DivOy:  offy_ff <= div_res[OW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      px = $signed({4'd0, cand_col_ff - 1'b1, 16'h8000}) - 32'(offx_ff);
      py = $signed({4'd0, cand_row_ff - 1'b1, 16'h8000}) - 32'(offy_ff);
      if (px < 0) px = '0;
      if (px > 32'sh1000_0000) px = 32'sh1000_0000;
      if (py < 0) py = '0;
      if (py > 32'sh1000_0000) py = 32'sh1000_0000;
   end

   assign peak_row        = cand_row_ff - 1'b1;
   assign peak_col        = RB'(cand_col_ff - 1'b1);
   assign peak_value      = win_ff[4];
   assign significance    = sig_ff;
   assign ellipticity_one = e1_ff;
   assign ellipticity_two = e2_ff;
   assign pos_x           = px[28:0];
   assign pos_y           = py[28:0];

endmodule

// ----- hw/rtl/local_max_peak_detector_core.sv -----
// ----------------------------------------------------------------------------
// local_max_peak_detector_core: 3x3 local-maximum peak detector
// Finds strict local maxima in a raster pixel stream and reports position,
// value, significance, ellipticity and parabolic sub-pixel position.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer
//  req_     | in        | one pixel, signed Q16.16
//  rsp_     | out       | one peak record
//  csr_     | in        | register write, no wait, no read-back
//
//  A pixel is accepted with a line store read, then shifted into the window
//  with a line store write, then peak tested. A peak adds five divisions
//  of a 56-bit quotient each through one shared bit-serial divider before
//  its record shows.
//  Synchronous reset clears the window and counters and sets configuration defaults;
//  line stores need no clearing. A stalled record holds the block until its transfer.
// ----------------------------------------------------------------------------
module local_max_peak_detector_core (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [31:0]    req_tdata,   // [31:0] pixel_value
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // [11:0] peak_row, [23:12] peak_col, [55:24] peak_value,
   // [87:56] significance, [103:88] ellipticity_one, [119:104] ellipticity_two,
   // [148:120] pos_x, [177:149] pos_y, [183:178] zero
   output logic [183:0]   rsp_tdata,
   input  logic           csr_we,
   input  logic [1:0]     csr_addr,
   input  logic [30:0]    csr_wdata
);

   lmpd_pkg::ctl_cmd_type cmd;
   lmpd_pkg::dp_sts_type  sts;

   logic [11:0]        peak_row, peak_col;
   logic signed [31:0] peak_value, significance;
   logic signed [15:0] ellipticity_one, ellipticity_two;
   logic [28:0]        pos_x, pos_y;

   // sequence intake, test and divisions
   lmpd_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold window, stores and results
   lmpd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .pixel_value     (req_tdata),
      .peak_row        (peak_row),
      .peak_col        (peak_col),
      .peak_value      (peak_value),
      .significance    (significance),
      .ellipticity_one (ellipticity_one),
      .ellipticity_two (ellipticity_two),
      .pos_x           (pos_x),
      .pos_y           (pos_y)
   );

   assign rsp_tdata = {6'd0, pos_y, pos_x, ellipticity_two, ellipticity_one,
                       significance, peak_value, peak_col, peak_row};

   // never take a pixel while a record is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("pixel accepted while a peak record is pending");

   // a division never completes in the cycle after its start
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !sts.div_done)
      else $error("divider finished too early");

   // no intake while a division is running
   a_div_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !req_tready)
      else $error("pixel intake open during division");

   // sub-pixel positions stay clamped
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_x <= 29'h1000_0000) && (pos_y <= 29'h1000_0000))
      else $error("sub-pixel position out of range");

endmodule
